>>> hdl/sb_pkg.sv
// ----------------------------------------------------------------------------
// Streebog hash package
// Shared constants, substitution table, linear map rows and round constants.
// Every 512-bit value is a flat vector: word 0 of the standard sits in bits
// 511:448 and byte 0 of the whole value in bits 7:0.
// ----------------------------------------------------------------------------
package sb_pkg;

	localparam int WordBytes = 8;
	localparam int StateBits = 512;
	localparam int Rounds    = 12;

	typedef logic [StateBits-1:0] sb_state_t;

	localparam logic [7:0] Sbox [0:255] = '{
		8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
		8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
		8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
		8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
		8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
		8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
		8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
		8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
		8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
		8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
		8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
		8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
		8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
		8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
		8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
		8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
		8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
		8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
		8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
		8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
		8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
		8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
		8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
		8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
		8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
		8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
		8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
		8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
		8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
		8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
		8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
		8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
	};

	// Row k is applied for input bit 63-k.
	localparam logic [63:0] LinTab [0:63] = '{
		64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
		64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
		64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
		64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
		64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
		64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
		64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
		64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
		64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
		64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
		64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
		64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
		64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
		64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
		64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
		64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
	};

	// Round constants, word 0 first.
	localparam sb_state_t RoundConst [0:Rounds-1] = '{
		{64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
		 64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
		{64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
		 64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
		{64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
		 64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
		{64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
		 64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
		{64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
		 64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
		{64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
		 64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
		{64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
		 64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
		{64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
		 64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
		{64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
		 64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
		{64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
		 64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
		{64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
		 64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
		{64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
		 64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
	};

	// Round constant by round number; unused codes give zero.
	function automatic sb_state_t round_const(input logic [3:0] r);
		sb_state_t v;
		v = '0;
		if (r < 4'(Rounds)) begin
			v = RoundConst[r];
		end
		return v;
	endfunction

endpackage

>>> hdl/sb_lps.sv
// ----------------------------------------------------------------------------
// Streebog LPS unit
// One full LPS transform of a 512-bit state: byte substitution, byte
// transposition and the 64x64 linear map on each word, all combinational.
// ----------------------------------------------------------------------------
module sb_lps
	import sb_pkg::*;
(
	input  sb_state_t a,
	output sb_state_t o
);

	sb_state_t sub;
	sb_state_t tr;

	// Substitute every byte.
	always_comb begin
		for (int b = 0; b < 64; b++) begin
			sub[8*b +: 8] = Sbox[a[8*b +: 8]];
		end
	end

	// Byte p*8+q of the result takes byte q*8+p of the substituted value.
	always_comb begin
		for (int p = 0; p < 8; p++) begin
			for (int q = 0; q < 8; q++) begin
				tr[(8*p+q)*8 +: 8] = sub[(8*q+p)*8 +: 8];
			end
		end
	end

	// Linear map: each set input bit adds one table row.
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			o[64*c +: 64] = '0;
			for (int i = 0; i < 64; i++) begin
				if (tr[64*c + i]) begin
					o[64*c +: 64] = o[64*c +: 64] ^ LinTab[63-i];
				end
			end
		end
	end

endmodule

>>> hdl/sb_compress.sv
// ----------------------------------------------------------------------------
// Streebog compression sequencer
// Runs g(h, n, m) on the shared LPS unit: one key step, then twelve rounds
// of a state step and a key step, then the final feed-forward. The inputs
// must stay stable from start until done.
// ----------------------------------------------------------------------------
module sb_compress
	import sb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sb_state_t h,
	input  sb_state_t n,
	input  sb_state_t m,
	output logic      done,
	output sb_state_t h_new
);

	localparam logic [4:0] LastStep = 5'(2*Rounds + 1);

	logic      busy_q;
	logic [4:0] step_q;
	sb_state_t k_q;
	sb_state_t st_q;
	sb_state_t lps_in;
	sb_state_t lps_out;
	logic [3:0] rnd;

	// Key steps are even (round number from step/2 - 1), state steps odd.
	assign rnd = step_q[4:1] - 4'd1;

	always_comb begin
		if (step_q == 5'd0) begin
			lps_in = h ^ n;
		end else if (step_q[0]) begin
			lps_in = k_q ^ st_q;
		end else begin
			lps_in = k_q ^ round_const(rnd);
		end
	end

	sb_lps u_lps (
		.a (lps_in),
		.o (lps_out)
	);

	assign done  = busy_q && (step_q == LastStep);
	assign h_new = k_q ^ st_q ^ h ^ m;

	// Step sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == LastStep) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 5'd1;
			end
		end
	end

	// Key and state registers.
	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= m;
		end else if (busy_q && step_q != LastStep) begin
			if (step_q[0]) begin
				st_q <= lps_out;
			end else begin
				k_q <= lps_out;
			end
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !start) else $error("compression restarted while finishing");

endmodule

>>> hdl/streebog_hash_engine.sv
// ----------------------------------------------------------------------------
// Streebog hash engine
// Top level: byte packing, length and checksum, padding and digest output.
// ----------------------------------------------------------------------------
// Each input transaction moves its valid bytes into the block one by one. A
// byte that completes a 64-byte block starts a compression on the single
// shared LPS unit, then the 64-bit-per-cycle length and checksum addition. A
// last word adds padding, the padded block's compression and addition, and
// the length and checksum compressions. Digest words leave one per accepted
// transaction. The input is not ready while a transaction is in work.
// ----------------------------------------------------------------------------
module streebog_hash_engine
	import sb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic        digest_last
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_PUSH, ST_PAD, ST_COMP, ST_ADD, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_BLOCK, PH_LEN, PH_SUM} phase_t;

	state_t    state_q;
	phase_t    phase_q;
	logic      mode_q;
	logic      msg_mode_q;
	logic      open_q;
	logic      fin_q;
	logic      pad_q;
	logic      go_q;
	logic      cy_n_q;
	logic      cy_s_q;
	logic [2:0] j_q;
	logic [2:0] oi_q;
	logic [3:0] nb_q;
	logic [3:0] cnt_q;
	logic [5:0] fill_q;
	logic [63:0] word_q;
	sb_state_t chain_q;
	sb_state_t n_q;
	sb_state_t s_q;
	sb_state_t blk_q;
	logic [63:0] out_word_q;
	logic      out_valid_q;
	logic      out_last_q;

	sb_state_t pad;
	sb_state_t comp_n;
	sb_state_t comp_m;
	sb_state_t h_new;
	logic      comp_done;
	logic [63:0] add_n_b;
	logic [64:0] sum_n;
	logic [64:0] sum_s;
	logic [2:0] last_idx;
	logic [2:0] oi_next;
	logic [3:0] nb_in;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign digest_word = out_word_q;
	assign digest_last = out_last_q;
	assign last_idx    = msg_mode_q ? 3'd3 : 3'd7;
	assign oi_next     = oi_q + 3'd1;
	assign nb_in       = (valid_bytes > 4'(WordBytes)) ? 4'(WordBytes) : valid_bytes;

	// Padded final block: data bytes, then 0x01, then zeros.
	always_comb begin
		for (int b = 0; b < 64; b++) begin
			if (6'(b) < fill_q) begin
				pad[8*b +: 8] = blk_q[8*b +: 8];
			end else if (6'(b) == fill_q) begin
				pad[8*b +: 8] = 8'h01;
			end else begin
				pad[8*b +: 8] = 8'h00;
			end
		end
	end

	// Compression operands by phase.
	always_comb begin
		case (phase_q)
			PH_BLOCK: begin
				comp_n = n_q;
				comp_m = blk_q;
			end
			PH_LEN: begin
				comp_n = '0;
				comp_m = n_q;
			end
			PH_SUM: begin
				comp_n = '0;
				comp_m = s_q;
			end
			default: begin
				comp_n = '0;
				comp_m = '0;
			end
		endcase
	end

	sb_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.h      (chain_q),
		.n      (comp_n),
		.m      (comp_m),
		.done   (comp_done),
		.h_new  (h_new)
	);

	// One 64-bit slice of the length and checksum additions per cycle.
	// A full block adds 512 bits; the padded block adds its data bits.
	always_comb begin
		add_n_b = '0;
		if (j_q == 3'd0) begin
			add_n_b = pad_q ? 64'({fill_q, 3'b000}) : 64'd512;
		end
		sum_n = {1'b0, n_q[64*j_q +: 64]} + {1'b0, add_n_b} + 65'(cy_n_q);
		sum_s = {1'b0, s_q[64*j_q +: 64]} + {1'b0, blk_q[64*j_q +: 64]} + 65'(cy_s_q);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// Main sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_BLOCK;
			msg_mode_q  <= 1'b0;
			open_q      <= 1'b0;
			fin_q       <= 1'b0;
			pad_q       <= 1'b0;
			go_q        <= 1'b0;
			cy_n_q      <= 1'b0;
			cy_s_q      <= 1'b0;
			j_q         <= '0;
			oi_q        <= '0;
			nb_q        <= '0;
			cnt_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			chain_q     <= '0;
			n_q         <= '0;
			s_q         <= '0;
		end else begin
			go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						word_q  <= message_word;
						nb_q    <= nb_in;
						fin_q   <= last_word;
						pad_q   <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_PUSH;
						if (!open_q) begin
							open_q     <= 1'b1;
							msg_mode_q <= mode_q;
							chain_q    <= mode_q ? {64{8'h01}} : '0;
							n_q        <= '0;
							s_q        <= '0;
							fill_q     <= '0;
						end
					end
				end
				ST_PUSH: begin
					if (cnt_q != nb_q) begin
						blk_q[{fill_q, 3'b000} +: 8] <= word_q[{cnt_q[2:0], 3'b000} +: 8];
						cnt_q <= cnt_q + 4'd1;
						if (fill_q == 6'd63) begin
							fill_q  <= '0;
							phase_q <= PH_BLOCK;
							go_q    <= 1'b1;
							state_q <= ST_COMP;
						end else begin
							fill_q <= fill_q + 6'd1;
						end
					end else begin
						state_q <= fin_q ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					blk_q   <= pad;
					pad_q   <= 1'b1;
					phase_q <= PH_BLOCK;
					go_q    <= 1'b1;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (comp_done) begin
						chain_q <= h_new;
						case (phase_q)
							PH_BLOCK: begin
								j_q     <= '0;
								cy_n_q  <= 1'b0;
								cy_s_q  <= 1'b0;
								state_q <= ST_ADD;
							end
							PH_LEN: begin
								phase_q <= PH_SUM;
								go_q    <= 1'b1;
							end
							default: begin
								out_word_q  <= h_new[511:448];
								out_valid_q <= 1'b1;
								out_last_q  <= 1'b0;
								oi_q        <= '0;
								state_q     <= ST_OUT;
							end
						endcase
					end
				end
				ST_ADD: begin
					n_q[64*j_q +: 64] <= sum_n[63:0];
					s_q[64*j_q +: 64] <= sum_s[63:0];
					cy_n_q <= sum_n[64];
					cy_s_q <= sum_s[64];
					j_q    <= j_q + 3'd1;
					if (j_q == 3'd7) begin
						if (pad_q) begin
							phase_q <= PH_LEN;
							go_q    <= 1'b1;
							state_q <= ST_COMP;
						end else begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						if (oi_q == last_idx) begin
							out_valid_q <= 1'b0;
							out_last_q  <= 1'b0;
							open_q      <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							oi_q       <= oi_next;
							out_word_q <= chain_q[{~oi_next, 6'b000000} +: 64];
							out_last_q <= (oi_next == last_idx);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_in_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input ready while digest pending");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && digest_last) |-> (oi_q == last_idx))
		else $error("digest end flag at wrong word");

	a_done_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		comp_done |-> (state_q == ST_COMP)) else $error("compression done outside wait");

	a_start_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |=> !go_q) else $error("compression start held two cycles");

endmodule

>>> tb/sv/streebog_digest_checker.sv
// ----------------------------------------------------------------------------
// Streebog digest checker
// Watches the configuration port and both channels of the hash engine. It
// keeps its own copy of the message state, computes the expected digest
// words on every accepted last word, and compares each output transaction
// field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module streebog_digest_checker
	import sb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] digest_word,
	input  logic        digest_last,
	output int          fail_count,
	output int          digests_pending
);

	typedef struct {
		logic [63:0] word;
		logic        last;
	} digest_entry_t;

	digest_entry_t digest_q[$];

	// Shadow of the engine state.
	logic      mode_reg;
	logic      msg_open;
	logic      msg_mode;
	sb_state_t chain_h;
	sb_state_t length_n;
	sb_state_t check_sum;
	sb_state_t block_data;
	int        fill;

	assign digests_pending = digest_q.size();

	// Linear map of one 64-bit word.
	function automatic logic [63:0] lin_map(input logic [63:0] x);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) begin
				r ^= LinTab[63-i];
			end
		end
		return r;
	endfunction

	// Substitution, byte transposition and linear map of a 512-bit state.
	function automatic sb_state_t lps_map(input sb_state_t a);
		logic [63:0] sub [8];
		logic [63:0] tr [8];
		sb_state_t o;
		for (int w = 0; w < 8; w++) begin
			for (int p = 0; p < 8; p++) begin
				sub[w][8*p +: 8] = Sbox[a[(7-w)*64 + 8*p +: 8]];
			end
		end
		for (int p = 0; p < 8; p++) begin
			for (int q = 0; q < 8; q++) begin
				tr[7-p][8*q +: 8] = sub[7-q][8*p +: 8];
			end
		end
		for (int w = 0; w < 8; w++) begin
			o[(7-w)*64 +: 64] = lin_map(tr[w]);
		end
		return o;
	endfunction

	// Compression function g with counter n and message block m.
	function automatic sb_state_t g_compress(input sb_state_t h, input sb_state_t n,
			input sb_state_t m);
		sb_state_t k, st;
		k = lps_map(h ^ n);
		st = m;
		for (int r = 0; r < Rounds; r++) begin
			st = lps_map(k ^ st);
			k = lps_map(k ^ RoundConst[r]);
		end
		return k ^ st ^ h ^ m;
	endfunction

	// Fold one accepted message word into the state; finish on a last word.
	task automatic absorb_word(input logic [63:0] word, input logic [3:0] nb_in,
			input logic last);
		int nb, cnt;
		sb_state_t m;
		if (!msg_open) begin
			msg_mode  = mode_reg;
			chain_h   = msg_mode ? {64{8'h01}} : '0;
			length_n  = '0;
			check_sum = '0;
			fill      = 0;
			msg_open  = 1'b1;
		end
		nb = (nb_in > 4'(WordBytes)) ? WordBytes : int'(nb_in);
		for (int i = 0; i < nb; i++) begin
			block_data[8*fill +: 8] = word[8*i +: 8];
			fill++;
			if (fill == 64) begin
				chain_h   = g_compress(chain_h, length_n, block_data);
				length_n  = length_n + 512;
				check_sum = check_sum + block_data;
				fill      = 0;
			end
		end
		if (last) begin
			// Padding: the collected bytes, then a single 0x01 byte.
			m = block_data & ((512'b1 << (8*fill)) - 1);
			m[8*fill +: 8] = 8'h01;
			chain_h   = g_compress(chain_h, length_n, m);
			length_n  = length_n + fill*8;
			check_sum = check_sum + m;
			chain_h   = g_compress(chain_h, '0, length_n);
			chain_h   = g_compress(chain_h, '0, check_sum);
			cnt = msg_mode ? 4 : 8;
			for (int i = 0; i < cnt; i++) begin
				digest_q.push_back('{chain_h[511-64*i -: 64], i == cnt-1});
			end
			msg_open = 1'b0;
		end
	endtask

	// Track transactions on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		digest_entry_t exp_e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			mode_reg   <= 1'b0;
			msg_open   <= 1'b0;
			msg_mode   <= 1'b0;
			fail_count <= 0;
			block_data <= '0;
			digest_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$error("digest transaction with nothing expected: word %h last %b",
						digest_word, digest_last);
					errs++;
				end else begin
					exp_e = digest_q.pop_front();
					if (digest_word !== exp_e.word) begin
						$error("digest_word expected %h actual %h", exp_e.word, digest_word);
						errs++;
					end
					if (digest_last !== exp_e.last) begin
						$error("digest_last expected %b actual %b", exp_e.last, digest_last);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (in_valid && in_ready) begin
				absorb_word(message_word, valid_bytes, last_word);
			end
			if (cfg_we) begin
				mode_reg <= cfg_wdata;
			end
		end
	end

endmodule

>>> tb/sv/streebog_hash_engine_test.sv
// ----------------------------------------------------------------------------
// Streebog hash engine test
// Drives directed and random messages in both digest modes into the engine,
// with random stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module streebog_hash_engine_test;

	localparam int StallLimit = 5000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] message_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] digest_word;
	logic        digest_last;
	int          fail_count;
	int          digests_pending;
	int          words_sent;
	int          quiet_cycles;
	logic        stalls_on;

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	streebog_hash_engine uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .message_word(message_word),
		.valid_bytes(valid_bytes), .last_word(last_word), .out_valid(out_valid),
		.out_ready(out_ready), .digest_word(digest_word), .digest_last(digest_last)
	);

	streebog_digest_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .message_word(message_word),
		.valid_bytes(valid_bytes), .last_word(last_word), .out_valid(out_valid),
		.out_ready(out_ready), .digest_word(digest_word), .digest_last(digest_last),
		.fail_count(fail_count), .digests_pending(digests_pending)
	);

	// Receiver stalls at random unless stalls are switched off.
	always @(negedge clk) begin
		out_ready <= stalls_on ? ($urandom_range(99) >= 21) : 1'b1;
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("streebog_hash_engine test failed");
				$finish;
			end
		end
	end

	// Offer one message word and hold it until the engine takes it.
	task automatic send_word(input logic [63:0] word, input logic [3:0] nb,
			input logic last);
		while (stalls_on && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		message_word <= word;
		valid_bytes  <= nb;
		last_word    <= last;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		words_sent++;
	endtask

	// Stop sending until every expected digest word has come out.
	task automatic drain_digests();
		in_valid <= 1'b0;
		@(negedge clk);
		while (digests_pending != 0) begin
			@(negedge clk);
		end
	endtask

	// Write the mode register while the engine is idle.
	task automatic write_mode(input logic m);
		drain_digests();
		repeat (80) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// A message of random words, mostly full ones.
	task automatic random_message(input int n_words);
		logic [3:0] nb;
		for (int i = 0; i < n_words; i++) begin
			nb = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'd8;
			send_word({$urandom, $urandom}, nb, 1'b0);
		end
		send_word({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		in_valid     = 1'b0;
		message_word = '0;
		valid_bytes  = '0;
		last_word    = 1'b0;
		stalls_on    = 1'b1;
		words_sent   = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty message, then single words at the field extremes.
		send_word('0, 4'd0, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word('1, 4'd15, 1'b1);
		send_word(64'h0123456789abcdef, 4'd1, 1'b1);
		// A zero-byte word inside a message and bytes above the valid count.
		send_word(64'hffff_ffff_ffff_ff5a, 4'd1, 1'b0);
		send_word('1, 4'd0, 1'b0);
		send_word(64'hdead_beef_cafe_f00d, 4'd7, 1'b1);
		// Exactly one full block, then an empty last word.
		for (int i = 0; i < 8; i++) begin
			send_word({$urandom, $urandom}, 4'd8, 1'b0);
		end
		send_word('0, 4'd0, 1'b1);
		// The 256-bit mode, and a mode change in the middle of a message.
		write_mode(1'b1);
		send_word('0, 4'd0, 1'b1);
		send_word('1, 4'd9, 1'b1);
		send_word({$urandom, $urandom}, 4'd8, 1'b0);
		write_mode(1'b0);
		send_word({$urandom, $urandom}, 4'd3, 1'b1);
		send_word({$urandom, $urandom}, 4'd8, 1'b0);
		write_mode(1'b1);
		send_word({$urandom, $urandom}, 4'd8, 1'b1);

		// Random messages; mostly short, some spanning several blocks.
		while (words_sent < 370) begin
			stalls_on = !(words_sent >= 150 && words_sent < 230);
			if ($urandom_range(3) == 0) begin
				write_mode(1'($urandom_range(1)));
			end else if ($urandom_range(5) == 0) begin
				drain_digests();
			end
			if ($urandom_range(5) == 0) begin
				random_message($urandom_range(16, 24));
			end else begin
				random_message($urandom_range(9));
			end
		end

		stalls_on = 1'b1;
		drain_digests();
		repeat (200) @(negedge clk);
		if (fail_count == 0) begin
			$display("streebog_hash_engine test passed");
		end else begin
			$display("streebog_hash_engine test failed");
		end
		$finish;
	end

endmodule

>>> streebog_hash_engine.f
hdl/sb_pkg.sv
hdl/sb_lps.sv
hdl/sb_compress.sv
hdl/streebog_hash_engine.sv
tb/sv/streebog_digest_checker.sv
tb/sv/streebog_hash_engine_test.sv
